### src/tstd_pkg.sv
// Package for the touch strip swipe/tap detector: shared types, register codes,
// event codes and reset values of the configuration registers.
// No dependencies.
package tstd_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TOUCH_LEVEL  = 3'd0,
        CFG_DRIFT_SHIFT  = 3'd1,
        CFG_SWIPE_WINDOW = 3'd2,
        CFG_TAP_WINDOW   = 3'd3,
        CFG_ABANDON      = 3'd4
    } cfg_addr_t;

    typedef enum logic [1:0] {
        KEY_NONE        = 2'd0,
        KEY_SCROLL_DOWN = 2'd1,
        KEY_SCROLL_UP   = 2'd2,
        KEY_TAP         = 2'd3
    } key_event_t;

    typedef enum logic {
        REQ_SAMPLE    = 1'b0,
        REQ_CALIBRATE = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [11:0] touch_level;
        logic [3:0]  drift_shift;
        logic [15:0] swipe_window_ms;
        logic [15:0] tap_window_ms;
        logic [15:0] abandon_ms;
    } cfg_t;

    localparam logic [11:0] RST_TOUCH_LEVEL  = 12'd40;
    localparam logic [3:0]  RST_DRIFT_SHIFT  = 4'd4;
    localparam logic [15:0] RST_SWIPE_WINDOW = 16'd300;
    localparam logic [15:0] RST_TAP_WINDOW   = 16'd180;
    localparam logic [15:0] RST_ABANDON      = 16'd900;

    typedef struct packed {
        req_type_t   req_type;
        logic [2:0]  pad_index;
        logic [11:0] charge_count;
        logic [31:0] now_ms;
        logic        scan_end;
    } item_t;

    // state update and result of one word
    typedef struct packed {
        logic        baseline_we;
        logic [11:0] baseline_wdata;
        logic        active_we;
        logic        active_wdata;
        logic        first_valid;
        logic        first_pad_we;
        logic        first_time_we;
        key_event_t  key_event;
        logic        pad_touched;
    } upd_t;

endpackage

### src/tstd_decide.sv
// Touch decision, baseline drift and swipe/tap/abandon logic for one word.
// Purely combinational; depends on tstd_pkg.
module tstd_decide import tstd_pkg::*; #(
    parameter int PAD_COUNT = 5
) (
    input  item_t                          item,
    input  cfg_t                           cfg,
    input  logic [11:0]                    baseline,
    input  logic                           active,
    input  logic                           first_valid,
    input  logic [$clog2(PAD_COUNT)-1:0]   first_pad,
    input  logic [31:0]                    first_time_ms,
    output upd_t                           upd
);

    localparam int PAD_W = $clog2(PAD_COUNT);

    logic [PAD_W-1:0]   idx;
    logic               in_range;
    logic signed [12:0] diff;
    logic signed [12:0] drift;
    logic signed [12:0] new_base;
    logic               touched;
    logic [31:0]        elapsed;
    logic               in_swipe;
    logic               in_tap;
    logic               over_abandon;
    logic               fv;
    logic               set_first;

    assign idx          = PAD_W'(item.pad_index);
    assign in_range     = 32'(item.pad_index) < 32'(PAD_COUNT);
    assign diff         = $signed({1'b0, item.charge_count}) - $signed({1'b0, baseline});
    assign touched      = diff > $signed({1'b0, cfg.touch_level});
    assign drift        = diff >>> cfg.drift_shift;
    assign new_base     = $signed({1'b0, baseline}) + drift;
    assign elapsed      = item.now_ms - first_time_ms;
    assign in_swipe     = elapsed < {16'd0, cfg.swipe_window_ms};
    assign in_tap       = elapsed < {16'd0, cfg.tap_window_ms};
    assign over_abandon = elapsed > {16'd0, cfg.abandon_ms};

    always_comb begin
        upd             = '0;
        upd.key_event   = KEY_NONE;
        upd.first_valid = first_valid;
        fv              = first_valid;
        set_first       = 1'b0;
        if (in_range) begin
            unique case (item.req_type)
                REQ_CALIBRATE: begin
                    upd.baseline_we    = 1'b1;
                    upd.baseline_wdata = item.charge_count;
                    upd.pad_touched    = active;
                end
                REQ_SAMPLE: begin
                    upd.baseline_we    = !touched;
                    upd.baseline_wdata = new_base[11:0];
                    if (touched && !active) begin
                        if (!fv) begin
                            fv                = 1'b1;
                            set_first         = 1'b1;
                            upd.first_pad_we  = 1'b1;
                            upd.first_time_we = 1'b1;
                        end else if (in_swipe) begin
                            if (idx > first_pad) begin
                                upd.key_event = KEY_SCROLL_DOWN;
                            end else if (idx < first_pad) begin
                                upd.key_event = KEY_SCROLL_UP;
                            end
                            upd.first_pad_we = 1'b1;
                        end
                    end
                    if (!touched && active && fv && first_pad == idx && in_tap) begin
                        upd.key_event = KEY_TAP;
                        fv            = 1'b0;
                    end
                    upd.active_we    = 1'b1;
                    upd.active_wdata = touched;
                    // a first pad set by this word has zero elapsed time
                    if (item.scan_end && fv && !set_first && over_abandon) begin
                        fv = 1'b0;
                    end
                    upd.first_valid = fv;
                    upd.pad_touched = touched;
                end
                default: begin
                    upd.pad_touched = 1'b0;
                end
            endcase
        end
    end

endmodule

### src/touch_strip_swipe_tap_detector_unit.sv
// Top level of the touch strip swipe/tap detector: stream ports, config
// registers, per-pad state and pipeline registers.
// Depends on tstd_pkg and tstd_decide.
//
// Usage:
//   Input stream (s_*): one word per pad measurement. s_tuser is the request
//   kind (sample or calibrate), s_tlast marks the last pad of a scan.
//   Output stream (m_*): exactly one word per input word, in order, carrying
//   the key event and the touched decision of the addressed pad.
//   Config port: cfg_wr_en writes cfg_wr_data to register cfg_addr;
//   write only while no word is in flight. Unknown addresses are ignored.
// Timing:
//   A word is registered at the input, evaluated and written to the output
//   register when the output stage can take it (empty, or m_tready high).
//   Throughput is one word per cycle while m_tready stays high; the per-pad state is updated in the
//   same cycle as the output register, so consecutive words see it directly.
// Reset (aresetn, synchronous): config returns to defaults, all pads untouched,
//   no first pad, both stages empty. Pad baselines must be calibrated again.
// Stall: while m_tready is low the output word holds; one more word can wait
//   in the input register, after which s_tready drops.
module touch_strip_swipe_tap_detector_unit import tstd_pkg::*; #(
    parameter int PAD_COUNT = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] pad_index, [14:3] charge_count, [46:15] now_ms, [47] zero
    input  logic [47:0]           s_tdata,
    // [0] req_type
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] key_event, [2] pad_touched, [7:3] zero
    output logic [7:0]            m_tdata
);

    localparam int PAD_W = $clog2(PAD_COUNT);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    item_t            in_item_reg;
    logic             out_valid_reg;
    key_event_t       out_key_reg;
    logic             out_touched_reg;
    logic [11:0]      baseline_reg [PAD_COUNT];
    logic [PAD_COUNT-1:0] active_reg;
    logic             first_valid_reg;
    logic [PAD_W-1:0] first_pad_reg;
    logic [31:0]      first_time_reg;

    item_t            s_item;
    logic             adv;
    logic [PAD_W-1:0] idx;
    upd_t             upd;

    assign s_item.req_type     = req_type_t'(s_tuser);
    assign s_item.pad_index    = s_tdata[2:0];
    assign s_item.charge_count = s_tdata[14:3];
    assign s_item.now_ms       = s_tdata[46:15];
    assign s_item.scan_end     = s_tlast;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign idx      = PAD_W'(in_item_reg.pad_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.touch_level     <= RST_TOUCH_LEVEL;
            cfg_reg.drift_shift     <= RST_DRIFT_SHIFT;
            cfg_reg.swipe_window_ms <= RST_SWIPE_WINDOW;
            cfg_reg.tap_window_ms   <= RST_TAP_WINDOW;
            cfg_reg.abandon_ms      <= RST_ABANDON;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TOUCH_LEVEL:  cfg_reg.touch_level     <= cfg_wr_data[11:0];
                CFG_DRIFT_SHIFT:  cfg_reg.drift_shift     <= cfg_wr_data[3:0];
                CFG_SWIPE_WINDOW: cfg_reg.swipe_window_ms <= cfg_wr_data;
                CFG_TAP_WINDOW:   cfg_reg.tap_window_ms   <= cfg_wr_data;
                CFG_ABANDON:      cfg_reg.abandon_ms      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
    end

    tstd_decide #(
        .PAD_COUNT (PAD_COUNT)
    ) u_decide (
        .item          (in_item_reg),
        .cfg           (cfg_reg),
        .baseline      (baseline_reg[idx]),
        .active        (active_reg[idx]),
        .first_valid   (first_valid_reg),
        .first_pad     (first_pad_reg),
        .first_time_ms (first_time_reg),
        .upd           (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            active_reg      <= '0;
            first_valid_reg <= 1'b0;
            first_pad_reg   <= '0;
            first_time_reg  <= '0;
        end else begin
            if (adv) begin
                out_valid_reg   <= 1'b1;
                first_valid_reg <= upd.first_valid;
                if (upd.active_we) begin
                    active_reg[idx] <= upd.active_wdata;
                end
                if (upd.first_pad_we) begin
                    first_pad_reg <= idx;
                end
                if (upd.first_time_we) begin
                    first_time_reg <= in_item_reg.now_ms;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_key_reg     <= upd.key_event;
            out_touched_reg <= upd.pad_touched;
            if (upd.baseline_we) begin
                baseline_reg[idx] <= upd.baseline_wdata;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_touched_reg, out_key_reg};

`ifndef SYNTHESIS
    a_tap_clears_first: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && upd.key_event == KEY_TAP |=> !first_valid_reg)
        else $error("tap did not clear first pad");

    a_scroll_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (upd.key_event == KEY_SCROLL_DOWN || upd.key_event == KEY_SCROLL_UP)
        |-> first_valid_reg)
        else $error("scroll without first pad");

    a_held_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_item_reg))
        else $error("waiting input word lost");

    a_out_of_range_no_state: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && 32'(in_item_reg.pad_index) >= 32'(PAD_COUNT)
        |=> $stable(active_reg) && $stable(first_valid_reg))
        else $error("out of range pad changed state");

    a_calibrate_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_item_reg.req_type == REQ_CALIBRATE |-> upd.key_event == KEY_NONE)
        else $error("calibrate produced an event");
`endif

endmodule
